@@ sv/pdds_pkg.sv @@
// Shared types and constants for the press duration delay setter.
package pdds_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned DelayW = 8;

  localparam logic [CountW-1:0] HOLD_TICKS_RESET   = CountW'(40);
  localparam logic [DelayW-1:0] STORED_DELAY_RESET = DelayW'(5);
  localparam logic [CountW-1:0] COUNT_MAX          = '1;

  typedef struct packed {
    logic              release_fire;
    logic [DelayW-1:0] delay_seconds;
    logic              setting_led;
  } pdds_result_t;

endpackage

@@ sv/pdds_in_if.sv @@
// Input channel: one sampled button level per transaction.
interface pdds_in_if;
  logic valid;
  logic ready;
  logic button_pressed;

  modport source (output valid, output button_pressed, input ready);
  modport sink   (input valid, input button_pressed, output ready);
endinterface

@@ sv/pdds_out_if.sv @@
// Output channel: one classification result per transaction.
interface pdds_out_if;
  logic       valid;
  logic       ready;
  logic       release_fire;
  logic [7:0] delay_seconds;
  logic       setting_led;

  modport source (output valid, output release_fire, output delay_seconds,
                  output setting_led, input ready);
  modport sink   (input valid, input release_fire, input delay_seconds,
                  input setting_led, output ready);
endinterface

@@ sv/pdds_in_reg.sv @@
// Input register stage holding one accepted button sample.
module pdds_in_reg (
  input  logic     clk_i,
  input  logic     rst_ni,
  pdds_in_if.sink  in_i,
  input  logic     advance_i,
  output logic     valid_o,
  output logic     level_o
);

  logic valid_q, valid_d;
  logic level_q;

  // Take a new sample when empty or when the held one moves on
  assign in_i.ready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      level_q <= in_i.button_pressed;
    end
  end

  assign valid_o = valid_q;
  assign level_o = level_q;

endmodule

@@ sv/pdds_core.sv @@
// Press classifier state and per-sample update logic.
module pdds_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       level_i,
  input  logic [15:0]                hold_ticks_i,
  output pdds_pkg::pdds_result_t     result_o
);
  import pdds_pkg::*;

  logic              prev_q, prev_d;
  logic [CountW-1:0] count_q, count_d;
  logic              mode_q, mode_d;
  logic [DelayW-1:0] pend_q, pend_d;
  logic [DelayW-1:0] stored_q, stored_d;

  logic release_edge;
  logic long_held;
  logic fire;
  logic enter;

  assign release_edge = prev_q && !level_i;
  assign long_held    = (count_q >= hold_ticks_i);
  assign fire         = release_edge && !mode_q && !long_held;
  assign enter        = release_edge && !mode_q && long_held;

  // Compute the state after this sample
  always_comb begin
    prev_d   = level_i;
    count_d  = count_q;
    mode_d   = mode_q;
    pend_d   = pend_q;
    stored_d = stored_q;
    if (fire) begin
      count_d = '0;
      pend_d  = '0;
    end else begin
      if (enter) begin
        mode_d = 1'b1;
        pend_d = '0;
      end else if (release_edge) begin
        pend_d = pend_q + DelayW'(1);
      end
      // Restart on a level change, otherwise count up and saturate
      if (prev_q != level_i) begin
        count_d = '0;
      end else if (count_q != COUNT_MAX) begin
        count_d = count_q + CountW'(1);
      end
      // Leave setting mode after a long steady level
      if (mode_d && (count_d >= hold_ticks_i)) begin
        mode_d   = 1'b0;
        stored_d = pend_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      count_q  <= '0;
      mode_q   <= 1'b0;
      pend_q   <= '0;
      stored_q <= STORED_DELAY_RESET;
    end else if (step_i) begin
      prev_q   <= prev_d;
      count_q  <= count_d;
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      stored_q <= stored_d;
    end
  end

  assign result_o.release_fire  = fire;
  assign result_o.delay_seconds = stored_d;
  assign result_o.setting_led   = mode_d;

endmodule

@@ sv/pdds_out_reg.sv @@
// Result register driving the output channel.
module pdds_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  pdds_pkg::pdds_result_t result_i,
  output logic                   ready_o,
  pdds_out_if.source             out_o
);
  import pdds_pkg::*;

  logic         valid_q, valid_d;
  pdds_result_t result_q;

  // Accept a new result when empty or when the held one is taken
  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.release_fire  = result_q.release_fire;
  assign out_o.delay_seconds = result_q.delay_seconds;
  assign out_o.setting_led   = result_q.setting_led;

endmodule

@@ sv/press_duration_delay_setter.sv @@
// Top level of the press duration delay setter.
//
// Feed one sampled button level per tick on in_i (valid/ready); each accepted
// transaction yields exactly one result transaction on out_o carrying
// release_fire, the stored delay_seconds and setting_led.
// hold_ticks is written through cfg_we_i/cfg_wdata_i; the user must write it only
// while the block is idle, which the block itself does not enforce; it resets to 40.
// A sample is registered in the input register at acceptance, classified while
// it is held there, and its result is registered in the result register once
// that has room. Throughput: one transaction per cycle while out_o does not
// stall, set by the single state update each sample makes in the classifier.
// Reset clears both pipeline registers, the press state and the pending
// count, and loads the stored delay with 5.
// When the receiver stalls, the result register holds its transaction, the
// input register holds one more sample, and in_i.ready then drops until the
// output drains. No transaction is lost or repeated.
module press_duration_delay_setter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  pdds_in_if.sink     in_i,
  pdds_out_if.source  out_o
);
  import pdds_pkg::*;

  logic [CountW-1:0] hold_ticks_q;
  logic              stage_valid;
  logic              stage_level;
  logic              out_ready;
  logic              advance;
  pdds_result_t      result;

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HOLD_TICKS_RESET;
    end else if (cfg_we_i) begin
      hold_ticks_q <= cfg_wdata_i;
    end
  end

  // Move a sample forward when the result register has room
  assign advance = stage_valid && out_ready;

  pdds_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .level_o   (stage_level)
  );

  pdds_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .level_i      (stage_level),
    .hold_ticks_i (hold_ticks_q),
    .result_o     (result)
  );

  pdds_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .ready_o  (out_ready),
    .out_o    (out_o)
  );

  // A firing press never happens inside setting mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.release_fire && out_o.setting_led))
    else $error("release fired while setting mode is active");

  // A classified sample always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_o.valid)
    else $error("classified sample lost before the output");

  // A waiting sample stays while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && !out_ready) |=> (stage_valid && $stable(stage_level)))
    else $error("input register dropped a sample during a stall");

endmodule

@@ dv/pdds_tick_checker.sv @@
// Checker that predicts every button tick and compares it with the result channel.
module pdds_tick_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pdds_pkg::CountW-1:0] cfg_wdata_i,
  pdds_in_if                          in_ch,
  pdds_out_if                         out_ch,
  output int unsigned                 fail_count_o,
  output int unsigned                 outstanding_o
);
  import pdds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxReports = 10;

  // Shadow copy of the register and of the press state
  logic [CountW-1:0] hold_ticks;
  logic              last_level;
  logic [CountW-1:0] steady_ticks;
  logic              in_setting;
  logic [DelayW-1:0] click_count;
  logic [DelayW-1:0] saved_delay;

  pdds_result_t predicted_outcomes[$];
  int unsigned  mismatches = 0;
  int unsigned  waiting    = 0;

  assign fail_count_o  = mismatches;
  assign outstanding_o = waiting;

  function automatic void clear_press_state();
    hold_ticks   = HOLD_TICKS_RESET;
    last_level   = 1'b0;
    steady_ticks = '0;
    in_setting   = 1'b0;
    click_count  = '0;
    saved_delay  = STORED_DELAY_RESET;
  endfunction

  // Advance the press state by one sampled level and return the tick's result
  function automatic pdds_result_t classify_tick(input logic level);
    pdds_result_t res;
    logic         fire;
    fire = 1'b0;
    if (last_level && !level) begin
      if (in_setting) begin
        steady_ticks = '0;
        click_count  = click_count + 1'b1;
      end else if (steady_ticks >= hold_ticks) begin
        in_setting   = 1'b1;
        steady_ticks = '0;
        click_count  = '0;
      end else begin
        fire = 1'b1;
      end
    end
    if (fire) begin
      // A short press clears the press state and does nothing else this tick
      last_level   = 1'b0;
      steady_ticks = '0;
      click_count  = '0;
    end else begin
      if (last_level != level) begin
        steady_ticks = '0;
      end else if (steady_ticks != COUNT_MAX) begin
        steady_ticks = steady_ticks + 1'b1;
      end
      if (in_setting && steady_ticks >= hold_ticks) begin
        in_setting  = 1'b0;
        saved_delay = click_count;
      end
      last_level = level;
    end
    res.release_fire  = fire;
    res.delay_seconds = saved_delay;
    res.setting_led   = in_setting;
    return res;
  endfunction

  // Compare finished transactions first, then queue the prediction for a new one
  always @(posedge clk_i or negedge rst_ni) begin
    pdds_result_t want;
    if (!rst_ni) begin
      clear_press_state();
      predicted_outcomes.delete();
    end else begin
      if (cfg_we_i) begin
        hold_ticks = cfg_wdata_i;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("%0t: unexpected result fire=%0d delay=%0d led=%0d", $realtime,
                     out_ch.release_fire, out_ch.delay_seconds, out_ch.setting_led);
          end
        end else begin
          want = predicted_outcomes.pop_front();
          if (out_ch.release_fire !== want.release_fire ||
              out_ch.delay_seconds !== want.delay_seconds ||
              out_ch.setting_led !== want.setting_led) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display({"%0t: mismatch expected fire=%0d delay=%0d led=%0d,",
                        " got fire=%0d delay=%0d led=%0d"},
                       $realtime, want.release_fire, want.delay_seconds, want.setting_led,
                       out_ch.release_fire, out_ch.delay_seconds, out_ch.setting_led);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_outcomes.push_back(classify_tick(in_ch.button_pressed));
      end
    end
    waiting = predicted_outcomes.size();
  end

endmodule

@@ dv/tb_press_duration_delay_setter.sv @@
// Testbench top: drives button ticks and hold settings, stalls results, gives the verdict.
module tb_press_duration_delay_setter;

  import pdds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned ResetTicks = 9;
  localparam int unsigned Latency    = 2;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SessionMax = 64;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [CountW-1:0] cfg_wdata;

  int unsigned       fail_count;
  int unsigned       outstanding;
  int unsigned       sent_items  = 0;
  int unsigned       cycle_count = 0;
  int unsigned       cur_hold    = 40;
  bit                gaps_on     = 1'b1;

  pdds_in_if  in_ch ();
  pdds_out_if out_ch ();

  press_duration_delay_setter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  pdds_tick_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stall the result channel in random bursts
  initial begin : result_stall
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && gaps_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic int unsigned cap_len(input int unsigned len, input int unsigned cap);
    return (len < cap) ? len : cap;
  endfunction

  // Present one level at a falling edge and hold it until the transaction is taken
  task automatic send_level(input logic level);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.button_pressed <= level;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic level, input int unsigned len);
    repeat (len) send_level(level);
  endtask

  // Hold off until every result is back, then let the pipeline settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (Latency + 2) @(negedge clk_i);
  endtask

  task automatic write_hold(input int unsigned ticks);
    wait_idle();
    cur_hold  = ticks;
    cfg_we    <= 1'b1;
    cfg_wdata <= CountW'(ticks);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic short_press();
    send_run(1'b0, $urandom_range(1, 4));
    send_run(1'b1, $urandom_range(1, cap_len(cur_hold, 12)));
    send_level(1'b0);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 16)) send_level(1'($urandom_range(0, 1)));
  endtask

  // Long press into setting mode, a run of clicks, then a steady level to leave it
  task automatic setting_session(input bit wrap_clicks);
    int unsigned clicks;
    int unsigned tap;
    send_run(1'b0, $urandom_range(1, 3));
    send_run(1'b1, cur_hold + 1 + $urandom_range(0, 3));
    send_level(1'b0);
    clicks = wrap_clicks ? $urandom_range(256, 300) : $urandom_range(0, 6);
    tap    = cap_len(cur_hold, 3);
    repeat (clicks) begin
      send_run(1'b1, wrap_clicks ? 1 : $urandom_range(1, tap));
      send_run(1'b0, wrap_clicks ? 1 : $urandom_range(1, tap));
    end
    if ($urandom_range(0, 1) == 1) begin
      send_run(1'b0, cur_hold + 1 + $urandom_range(0, 2));
    end else begin
      // leave by holding the button, which re-enters on release
      send_run(1'b1, cur_hold + 1 + $urandom_range(0, 2));
      send_run(1'b0, cur_hold + 2);
    end
  endtask

  task automatic run_random(input int unsigned budget, input bit wrap_first);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = sent_items + budget;
    if (wrap_first) begin
      setting_session(1'b1);
    end
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        short_press();
      end else if (pick < 8 && cur_hold <= SessionMax) begin
        setting_session(1'b0);
      end else begin
        noise_burst();
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.button_pressed = 1'b0;
    repeat (ResetTicks) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset hold of 40: two short presses fire with the reset delay
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b0);
    send_run(1'b1, 2);
    send_level(1'b0);

    // Hold of 2: enter, two clicks, leave by low level, fire with the new delay
    write_hold(2);
    send_level(1'b0);
    send_run(1'b1, 3);
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b0);
    send_run(1'b0, 2);
    send_level(1'b1);
    send_level(1'b0);
    // enter, leave setting mode by holding the button, then re-enter and leave by low level
    send_run(1'b1, 3);
    send_level(1'b0);
    send_run(1'b1, 3);
    send_level(1'b0);
    send_run(1'b0, 3);

    // Random phases with gaps on both sides; the hold of 3 wraps the click count
    write_hold(1);
    run_random(200, 1'b0);
    write_hold(3);
    run_random(600, 1'b1);
    write_hold(40);
    run_random(150, 1'b0);
    write_hold($urandom_range(4, 30));
    run_random(150, 1'b0);

    // Long hold: a long press enters, a long low level leaves with delay 0
    gaps_on = 1'b0;
    write_hold(120);
    send_run(1'b1, 125);
    send_run(1'b0, 125);
    repeat (5) short_press();

    // Last stretch runs without gaps
    write_hold(5);
    run_random(150, 1'b0);

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
